// File: rtl/core/lexical_token_scanner_assert.svh
// Assertion macros shared by the lexical token scanner RTL.
`ifndef LEXICAL_TOKEN_SCANNER_ASSERT_SVH
`define LEXICAL_TOKEN_SCANNER_ASSERT_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define LTS_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lexical_token_scanner: check failed");

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define LTS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lexical_token_scanner: check failed");

`endif

// File: rtl/core/lts_pkg.sv
// Types, codes and constants of the lexical token scanner.
package lts_pkg;

  localparam int unsigned MAX_IDENT_CHARS = 8;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // Keywords packed with the first character in the lowest byte
  localparam logic [63:0] KW_IF   = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_THEN = 64'h0000_0000_6E65_6874;
  localparam logic [63:0] KW_ELSE = 64'h0000_0000_6573_6C65;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_COMMENT = 3'd1,
    ST_IDENT   = 3'd2,
    ST_NUMBER  = 3'd3,
    ST_LESS    = 3'd4,
    ST_COLON   = 3'd5,
    ST_HALT    = 3'd6
  } scan_state_t;

  typedef enum logic [3:0] {
    TK_IDENT  = 4'd0,
    TK_NUMBER = 4'd1,
    TK_PLUS   = 4'd2,
    TK_MINUS  = 4'd3,
    TK_LESS   = 4'd4,
    TK_LESSEQ = 4'd5,
    TK_ASSIGN = 4'd6,
    TK_IF     = 4'd7,
    TK_THEN   = 4'd8,
    TK_ELSE   = 4'd9,
    TK_END    = 4'd10,
    TK_ERROR  = 4'd11
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [30:0] num;
    logic [63:0] text;
    logic [3:0]  len;
    logic        lim;
    logic        last;
  } tok_t;

  // Results of one input item, in order
  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } scan_push_t;

  function automatic tok_t plain_tok(token_kind_t kind);
    tok_t t;
    t      = '0;
    t.kind = kind;
    return t;
  endfunction

endpackage

// File: rtl/core/lts_scan.sv
// Scanner state machine: consumes one byte per transfer, builds up to two tokens.
module lts_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          char_code,
  input  logic                end_of_input,
  output lts_pkg::scan_push_t push,
  output lts_pkg::scan_state_t state
);
  import lts_pkg::*;

  scan_state_t state_r, state_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        lim_r, lim_nxt;

  logic        is_let, is_dig, use_start;
  logic        first_v, second_v;
  tok_t        first_t, second_t, ident_t;
  token_kind_t ident_kind;
  logic [34:0] acc_ext;
  logic [3:0]  digit;

  assign is_let = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                  ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign digit  = 4'(char_code - CH_ZERO);

  // acc * 10 + digit as two shifted adds
  assign acc_ext = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, digit};

  always_comb begin
    ident_kind = TK_IDENT;
    if (!lim_r) begin
      if (cnt_r == 4'd2 && buf_r == KW_IF) ident_kind = TK_IF;
      else if (cnt_r == 4'd4 && buf_r == KW_THEN) ident_kind = TK_THEN;
      else if (cnt_r == 4'd4 && buf_r == KW_ELSE) ident_kind = TK_ELSE;
    end
    if (ident_kind == TK_IDENT) begin
      ident_t      = plain_tok(TK_IDENT);
      ident_t.text = buf_r;
      ident_t.len  = cnt_r;
      ident_t.lim  = lim_r;
    end else begin
      ident_t = plain_tok(ident_kind);
    end
  end

  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    lim_nxt   = lim_r;
    use_start = 1'b0;
    first_v   = 1'b0;
    first_t   = plain_tok(TK_ERROR);
    second_v  = 1'b0;
    second_t  = plain_tok(TK_ERROR);
    push      = '0;

    unique case (state_r)
      ST_START: use_start = 1'b1;
      ST_COMMENT: begin
        if (end_of_input) begin
          first_v   = 1'b1;
          state_nxt = ST_HALT;
        end else if (char_code == CH_RBRACE) begin
          state_nxt = ST_START;
        end
      end
      ST_IDENT: begin
        if (!end_of_input && (is_let || is_dig)) begin
          if (cnt_r < 4'(MAX_IDENT_CHARS)) begin
            for (int i = 0; i < 8; i++) begin
              if (cnt_r == 4'(i)) buf_nxt[8*i +: 8] = char_code;
            end
            cnt_nxt = cnt_r + 4'd1;
          end else begin
            lim_nxt = 1'b1;
          end
        end else begin
          first_v   = 1'b1;
          first_t   = ident_t;
          use_start = 1'b1;
        end
      end
      ST_NUMBER: begin
        if (!end_of_input && is_dig) begin
          if (acc_ext > {4'd0, NUM_MAX}) begin
            acc_nxt = NUM_MAX;
            lim_nxt = 1'b1;
          end else begin
            acc_nxt = acc_ext[30:0];
          end
        end else begin
          first_v     = 1'b1;
          first_t     = plain_tok(TK_NUMBER);
          first_t.num = acc_r;
          first_t.lim = lim_r;
          use_start   = 1'b1;
        end
      end
      ST_LESS: begin
        first_v = 1'b1;
        if (!end_of_input && char_code == CH_EQUAL) begin
          first_t   = plain_tok(TK_LESSEQ);
          state_nxt = ST_START;
        end else begin
          first_t   = plain_tok(TK_LESS);
          use_start = 1'b1;
        end
      end
      ST_COLON: begin
        first_v = 1'b1;
        if (!end_of_input && char_code == CH_EQUAL) begin
          first_t   = plain_tok(TK_ASSIGN);
          state_nxt = ST_START;
        end else begin
          state_nxt = ST_HALT;
        end
      end
      default: state_nxt = ST_HALT;
    endcase

    // Handle the byte from the start state
    if (use_start) begin
      state_nxt = ST_START;
      if (end_of_input) begin
        second_v  = 1'b1;
        second_t  = plain_tok(TK_END);
        state_nxt = ST_HALT;
      end else if (char_code == CH_LBRACE) begin
        state_nxt = ST_COMMENT;
      end else if (char_code == CH_PLUS) begin
        second_v = 1'b1;
        second_t = plain_tok(TK_PLUS);
      end else if (char_code == CH_MINUS) begin
        second_v = 1'b1;
        second_t = plain_tok(TK_MINUS);
      end else if (char_code == CH_LESS) begin
        state_nxt = ST_LESS;
      end else if (char_code == CH_COLON) begin
        state_nxt = ST_COLON;
      end else if (char_code <= CH_SPACE) begin
        state_nxt = ST_START;
      end else if (is_let) begin
        buf_nxt   = {56'd0, char_code};
        cnt_nxt   = 4'd1;
        lim_nxt   = 1'b0;
        state_nxt = ST_IDENT;
      end else if (is_dig) begin
        acc_nxt   = {27'd0, digit};
        lim_nxt   = 1'b0;
        state_nxt = ST_NUMBER;
      end else begin
        second_v  = 1'b1;
        state_nxt = ST_HALT;
      end
    end

    // Pack results in order and mark the final one
    if (first_v && second_v) begin
      push.n       = 2'd2;
      push.r0      = first_t;
      push.r1      = second_t;
      push.r1.last = 1'b1;
    end else if (first_v) begin
      push.n       = 2'd1;
      push.r0      = first_t;
      push.r0.last = 1'b1;
    end else if (second_v) begin
      push.n       = 2'd1;
      push.r0      = second_t;
      push.r0.last = 1'b1;
    end
  end

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      buf_r   <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      lim_r   <= 1'b0;
    end else if (take) begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule

// File: rtl/core/lts_outq.sv
// Four-entry result queue: takes up to two tokens per cycle, hands out one.
module lts_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_en,
  input  lts_pkg::scan_push_t push,
  input  logic                pop,
  output lts_pkg::tok_t       head,
  output logic                head_valid,
  output logic                room,
  output logic [2:0]          level
);
  import lts_pkg::*;

  tok_t       q_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;

  assign n_in   = push_en ? push.n : 2'd0;
  assign wp_nxt = wp_r + n_in;
  assign rp_nxt = rp_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, n_in} - {2'b00, pop};

  assign head       = q_r[rp_r];
  assign head_valid = (cnt_r != 3'd0);
  assign room       = (cnt_r <= 3'd2);
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) q_r[wp_r] <= push.r0;
    if (n_in == 2'd2) q_r[wp_r + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/lexical_token_scanner.sv
// Lexical token scanner top level: byte-driven scanner feeding a result queue.
// A token is queued at the byte transfer that ends it, then leaves on out_.
// One byte per cycle unless stalled; two tokens from one byte leave one at a time.
// Input stalls while the four-entry result queue holds more than two tokens.
// After an end or error token the scanner halts: bytes are taken, no tokens made.
// Reset (rst_n low, synchronous) returns to the start state and empties the queue.
module lexical_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [30:0] out_number_value,
  output logic [63:0] out_ident_text,
  output logic [3:0]  out_ident_length,
  output logic        out_limit_flag,
  output logic        out_last_of_run
);
  import lts_pkg::*;

  scan_push_t  push;
  scan_state_t state;
  tok_t        head;
  logic        take, pop, room;
  logic [2:0]  level;

  assign in_stall = !room;
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  lts_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .char_code    (in_char_code),
    .end_of_input (in_end_of_input),
    .push         (push),
    .state        (state)
  );

  lts_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (take),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .room       (room),
    .level      (level)
  );

  assign out_token_kind   = head.kind;
  assign out_number_value = head.num;
  assign out_ident_text   = head.text;
  assign out_ident_length = head.len;
  assign out_limit_flag   = head.lim;
  assign out_last_of_run  = head.last;

`include "lexical_token_scanner_assert.svh"

  `LTS_ASSERT_NEXT(a_end_halts, take && in_end_of_input, state == ST_HALT)
  `LTS_ASSERT_NEXT(a_halt_sticks, state == ST_HALT, state == ST_HALT)
  `LTS_ASSERT_SAME(a_halt_silent, state == ST_HALT, push.n == 2'd0)
  `LTS_ASSERT_SAME(a_queue_bound, 1'b1, level <= 3'd4)

endmodule

// File: test/scan_checker.sv
// Token checker for the lexical token scanner: tracks the byte stream and compares tokens.
`timescale 1ns / 100ps

module scan_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_token_kind,
  input  logic [30:0] out_number_value,
  input  logic [63:0] out_ident_text,
  input  logic [3:0]  out_ident_length,
  input  logic        out_limit_flag,
  input  logic        out_last_of_run,
  output int          fails,
  output int          pending,
  output int          checked
);
  import lts_pkg::*;

  scan_state_t st;
  logic [63:0] id_text;
  logic [3:0]  id_len;
  logic [30:0] num_acc;
  logic        cut_or_sat;

  tok_t expected_tokens[$];
  tok_t step_toks[2];
  int   step_n;
  int   mism = 0;
  int   matched = 0;

  function automatic logic alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mism++;
    $display("%0t: token mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic add_tok(input token_kind_t k, input logic [30:0] num,
                         input logic [63:0] text, input logic [3:0] len, input logic lim);
    tok_t t;
    t.kind = k;
    t.num  = num;
    t.text = text;
    t.len  = len;
    t.lim  = lim;
    t.last = 1'b0;
    if (step_n < 2) begin
      step_toks[step_n] = t;
      step_n++;
    end
  endtask

  // Handle a byte from the start state
  task automatic begin_token(input logic [7:0] c, input logic e);
    if (e) begin
      add_tok(TK_END, '0, '0, '0, 1'b0);
      st = ST_HALT;
    end else begin
      st = ST_START;
      if (c == CH_LBRACE) begin
        st = ST_COMMENT;
      end else if (c == CH_PLUS) begin
        add_tok(TK_PLUS, '0, '0, '0, 1'b0);
      end else if (c == CH_MINUS) begin
        add_tok(TK_MINUS, '0, '0, '0, 1'b0);
      end else if (c == CH_LESS) begin
        st = ST_LESS;
      end else if (c == CH_COLON) begin
        st = ST_COLON;
      end else if (c <= CH_SPACE) begin
        // skip whitespace
      end else if (alpha(c)) begin
        id_text    = {56'd0, c};
        id_len     = 4'd1;
        cut_or_sat = 1'b0;
        st         = ST_IDENT;
      end else if (numeral(c)) begin
        num_acc    = {23'd0, c - CH_ZERO};
        cut_or_sat = 1'b0;
        st         = ST_NUMBER;
      end else begin
        add_tok(TK_ERROR, '0, '0, '0, 1'b0);
        st = ST_HALT;
      end
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic e);
    token_kind_t kw;
    logic [34:0] grown;
    tok_t        t;
    step_n = 0;
    case (st)
      ST_START: begin
        begin_token(c, e);
      end
      ST_COMMENT: begin
        if (e) begin
          add_tok(TK_ERROR, '0, '0, '0, 1'b0);
          st = ST_HALT;
        end else if (c == CH_RBRACE) begin
          st = ST_START;
        end
      end
      ST_IDENT: begin
        if (!e && (alpha(c) || numeral(c))) begin
          if (id_len < MAX_IDENT_CHARS) begin
            id_text = id_text | ({56'd0, c} << (8 * id_len));
            id_len++;
          end else begin
            cut_or_sat = 1'b1;
          end
        end else begin
          kw = TK_IDENT;
          if (!cut_or_sat) begin
            if (id_len == 4'd2 && id_text == KW_IF) kw = TK_IF;
            else if (id_len == 4'd4 && id_text == KW_THEN) kw = TK_THEN;
            else if (id_len == 4'd4 && id_text == KW_ELSE) kw = TK_ELSE;
          end
          if (kw == TK_IDENT) add_tok(TK_IDENT, '0, id_text, id_len, cut_or_sat);
          else add_tok(kw, '0, '0, '0, 1'b0);
          begin_token(c, e);
        end
      end
      ST_NUMBER: begin
        if (!e && numeral(c)) begin
          grown = {4'd0, num_acc} * 35'd10 + {27'd0, c - CH_ZERO};
          if (grown > {4'd0, NUM_MAX}) begin
            grown      = {4'd0, NUM_MAX};
            cut_or_sat = 1'b1;
          end
          num_acc = grown[30:0];
        end else begin
          add_tok(TK_NUMBER, num_acc, '0, '0, cut_or_sat);
          begin_token(c, e);
        end
      end
      ST_LESS: begin
        if (!e && c == CH_EQUAL) begin
          add_tok(TK_LESSEQ, '0, '0, '0, 1'b0);
          st = ST_START;
        end else begin
          add_tok(TK_LESS, '0, '0, '0, 1'b0);
          begin_token(c, e);
        end
      end
      ST_COLON: begin
        // a colon must be followed by '=', anything else halts
        if (!e && c == CH_EQUAL) begin
          add_tok(TK_ASSIGN, '0, '0, '0, 1'b0);
          st = ST_START;
        end else begin
          add_tok(TK_ERROR, '0, '0, '0, 1'b0);
          st = ST_HALT;
        end
      end
      default: begin
        st = ST_HALT;
      end
    endcase
    if (step_n > 0) begin
      t = step_toks[step_n - 1];
      t.last = 1'b1;
      step_toks[step_n - 1] = t;
    end
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_toks[i]);
  endtask

  always @(posedge clk) begin : watch
    tok_t want;
    if (!rst_n) begin
      st         = ST_START;
      id_text    = '0;
      id_len     = '0;
      num_acc    = '0;
      cut_or_sat = 1'b0;
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report("token with nothing expected", 64'(out_token_kind), '0);
        end else begin
          want = expected_tokens.pop_front();
          matched++;
          if (out_token_kind !== want.kind)
            report("kind", 64'(out_token_kind), 64'(want.kind));
          if (out_number_value !== want.num)
            report("number", 64'(out_number_value), 64'(want.num));
          if (out_ident_text !== want.text)
            report("ident text", out_ident_text, want.text);
          if (out_ident_length !== want.len)
            report("ident length", 64'(out_ident_length), 64'(want.len));
          if (out_limit_flag !== want.lim)
            report("limit flag", 64'(out_limit_flag), 64'(want.lim));
          if (out_last_of_run !== want.last)
            report("last flag", 64'(out_last_of_run), 64'(want.last));
        end
      end
      if (in_valid && !in_stall) scan_byte(in_char_code, in_end_of_input);
    end
    fails   <= mism;
    pending <= expected_tokens.size();
    checked <= matched;
  end

endmodule

// File: test/tb.sv
// Top testbench for the lexical token scanner: stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb;
  import lts_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_token_kind;
  logic [30:0] out_number_value;
  logic [63:0] out_ident_text;
  logic [3:0]  out_ident_length;
  logic        out_limit_flag;
  logic        out_last_of_run;

  int    fails;
  int    pending;
  int    checked;
  int    sent;
  int    burst_left;
  string closer;

  lexical_token_scanner uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_ident_text   (out_ident_text),
    .out_ident_length (out_ident_length),
    .out_limit_flag   (out_limit_flag),
    .out_last_of_run  (out_last_of_run)
  );

  scan_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_ident_text   (out_ident_text),
    .out_ident_length (out_ident_length),
    .out_limit_flag   (out_limit_flag),
    .out_last_of_run  (out_last_of_run),
    .fails            (fails),
    .pending          (pending),
    .checked          (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

  // Output side: stall in modes of random length, with two long hold-offs
  initial begin : receiver
    int cyc;
    int mode;
    int span;
    cyc = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        if (cyc == 300 || cyc == 1500) begin
          out_stall <= 1'b1;
          repeat (120) @(posedge clk);
          cyc += 120;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cyc % 3 == 0);
        endcase
        @(posedge clk);
        cyc++;
      end
    end
  end

  // Offer one item and hold it until the transfer; open a new burst when due
  task automatic send_item(input logic [7:0] c, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_char_code    <= c;
    in_end_of_input <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // One well-formed piece of source text; never halts the scanner
  task automatic send_fragment();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0: repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 32)), 1'b0);
      1, 2: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        send_item(rand_letter(), 1'b0);
        repeat (n - 1) send_item($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter(), 1'b0);
      end
      3: begin
        case ($urandom_range(0, 6))
          0: send_text("if");
          1: send_text("then");
          2: send_text("else");
          3: send_text("iff");
          4: send_text("then0");
          5: send_text("els");
          default: send_text("IF");
        endcase
      end
      4, 5: begin
        case ($urandom_range(0, 11))
          0: send_text("2147483647");
          1: send_text("2147483648");
          2: repeat ($urandom_range(10, 13)) send_item(rand_digit(), 1'b0);
          default: repeat ($urandom_range(1, 6)) send_item(rand_digit(), 1'b0);
        endcase
      end
      6: send_item(CH_PLUS, 1'b0);
      7: send_item(CH_MINUS, 1'b0);
      8: begin
        send_item(CH_LESS, 1'b0);
        if ($urandom_range(0, 1)) send_item(CH_EQUAL, 1'b0);
      end
      9: send_text(":=");
      10: begin
        send_item(CH_LBRACE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_RBRACE);
          send_item(c, 1'b0);
        end
        send_item(CH_RBRACE, 1'b0);
      end
      default: send_item(CH_SPACE, 1'b0);
    endcase
  endtask

  initial begin : stimulus
    int guard;
    logic [7:0] c;
    sent            = 0;
    burst_left      = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_char_code    <= '0;
    in_end_of_input <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, NUL and space, byte 255 in a comment, letter and digit
    // extremes, a token ended by the next byte, all operators
    send_text("if");
    send_item(8'h00, 1'b0);
    send_text("then else");
    send_item(CH_LBRACE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_text("Zz09+9-<<=:=");

    while (sent < 800) send_fragment();

    // close the stream one way; the scanner halts for good after this
    case ($urandom_range(0, 6))
      0: begin
        closer = "end mark after whitespace";
        send_item(CH_SPACE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        closer = "end mark right after an identifier";
        send_text(" xq7");
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        closer = "end mark right after a number";
        send_text(" 42");
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      3: begin
        closer = "end mark right after a less sign";
        send_item(CH_LESS, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      4: begin
        closer = "stray byte";
        do begin
          c = 8'($urandom_range(33, 255));
        end while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                   (c >= "0" && c <= "9") || c == CH_LBRACE || c == CH_PLUS ||
                   c == CH_MINUS || c == CH_LESS || c == CH_COLON);
        send_item(c, 1'b0);
      end
      5: begin
        closer = "lone colon";
        send_item(CH_COLON, 1'b0);
        if ($urandom_range(0, 1)) begin
          send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_EQUAL);
          send_item(c, 1'b0);
        end
      end
      default: begin
        closer = "end mark inside a comment";
        send_item(CH_LBRACE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase

    // halted: these must produce nothing
    repeat ($urandom_range(3, 10))
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    $display("summary: %0d input transfers, %0d tokens checked field by field", sent, checked);
    $display("summary: stream closed by %s, with output hold-offs that filled the queue",
             closer);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
